// ===== rtl/keyed_base64_codec_top_assert.svh =====
// ----------------------------------------------------------------------------
// keyed_base64_codec_top_assert.svh
// Assertion macros used by the codec emitter; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef KEYED_BASE64_CODEC_TOP_ASSERT_SVH
`define KEYED_BASE64_CODEC_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// condition that must hold at every clock edge out of reset
`define KB64_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);
// antecedent in one cycle implies consequent in the next
`define KB64_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
// antecedent implies consequent in the same cycle
`define KB64_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define KB64_ASSERT_ALWAYS(name, cond, msg)
`define KB64_ASSERT_NEXT(name, ante, cons, msg)
`define KB64_ASSERT_SAME(name, ante, cons, msg)
`endif

`endif

// ===== rtl/kb64_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kb64_pkg
// Types, constants and alphabet lookups of the keyed base64 codec.
// ----------------------------------------------------------------------------
package kb64_pkg;

    localparam int TABLE_ROWS    = 10;
    localparam int NUM_ALPHABETS = 10;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 4;
    localparam int SEL_W         = 4;
    localparam int WORD_W        = 24;
    localparam int BITS_W        = 18;

    localparam logic [CFG_INDEX_W-1:0] REG_ALPHABET_SELECT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECODE_MODE     = 2'd1;

    // first symbol sits in the top byte of each row
    localparam logic [511:0] ALPHABETS [TABLE_ROWS] = '{
        "3uqSv9iNBJIj+y8M0VE2omKLH4nzPphc5d7ADgsUWk/xw6tGClQeabfOXYrZFTR1",
        "iLW9g0lwKQ34/SPzdYj6Zonyu2eq1pABICN5mJT8MFEsRx+hUtaGvrDHcXfkO7Vb",
        "1lIcJYGgE+a4oSsv0e8yf6N5DndQuFxwX/CkMOTzK7i2qB9At3mLjhVbHpRrPWZU",
        "MqTyOYdfsCHx+SlKW7hDnJ4zbZup1mR5tEFGwr9L6v8A2PeI/0QUgVjX3kcNiaBo",
        "ItBn9/VhKoFx3ZLG7Ss8AwjXkDTf6q5UbrPdWlmRYO42CgM1Ju0pQEHvzNya+cie",
        "1aDOEiU0YTPrJGcFRNMWLjl/ZtC+ewHIBAVg3KXq4dyQpsSb72vn5fzoxuhkm698",
        "9lu7MvHWehi+SwJ1KQ8DOGj4npxANarF32qToIbLd6f/VZPyBszYgtXkmCcU0R5E",
        "Tj0zyn7M8eUHLhpuPxOlsF94r+Bqt2AR5/idabQD3kZSYNKg1IvJVfwCXmEWoc6G",
        "9PjkHXCh2ZI1fS+RzKmDTeu0wv3FUJnMGBd8qsa6c5QtNgVEbrOpWyoLli4YA7x/",
        "5saogw80WTz3SJnPxjAL2/K6GMb1rdIXVkptYHE7B9+yfFNmDe4chQvURuilCOqZ"
    };

    typedef struct packed {
        logic [7:0] data;
        logic [5:0] idx;
        logic       last;
    } front_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } group_t;

    function automatic logic [7:0] symbol_of(input logic [SEL_W-1:0] row,
                                             input logic [5:0] idx);
        logic [7:0] sym;
        sym = 8'd0;
        if (row < SEL_W'(TABLE_ROWS)) begin
            sym = ALPHABETS[row][8*(63 - int'(idx)) +: 8];
        end
        return sym;
    endfunction

    // alphabets are permutations, so at most one position matches
    function automatic logic [5:0] index_of(input logic [SEL_W-1:0] row,
                                            input logic [7:0] ch);
        logic [5:0] res;
        res = 6'd0;
        if (row < SEL_W'(TABLE_ROWS)) begin
            for (int i = 0; i < 64; i++) begin
                if (ALPHABETS[row][8*(63 - i) +: 8] == ch) begin
                    res = res | 6'(i);
                end
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/kb64_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kb64_front
// Input register stage with the synchronous symbol-to-index lookup.
// ----------------------------------------------------------------------------
module kb64_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic                           s_tlast,
    input  logic                           sel_ok,
    input  logic [kb64_pkg::SEL_W-1:0]     sel,
    output logic                           f_valid,
    output kb64_pkg::front_item_t          f_item,
    input  logic                           f_ready
);

    logic                  valid_reg, valid_next;
    kb64_pkg::front_item_t item_reg;
    logic                  accept;

    assign s_tready = !valid_reg || f_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (f_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // lookup ROM read, registered with the item
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.data <= s_tdata;
            item_reg.idx  <= sel_ok ? kb64_pkg::index_of(sel, s_tdata) : 6'd0;
            item_reg.last <= s_tlast;
        end
    end

    assign f_valid = valid_reg;
    assign f_item  = item_reg;

endmodule

// ===== rtl/kb64_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kb64_packer
// Gathers bytes or sextets of the open group and releases whole or short final groups.
// ----------------------------------------------------------------------------
module kb64_packer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  decode_mode,
    input  logic                  clear,
    input  logic                  f_valid,
    input  kb64_pkg::front_item_t f_item,
    output logic                  f_ready,
    output logic                  grp_valid,
    output kb64_pkg::group_t      grp,
    input  logic                  grp_ready
);

    logic [kb64_pkg::BITS_W-1:0] group_bits_reg, group_bits_next;
    logic [1:0]                  group_count_reg, group_count_next;
    logic [kb64_pkg::WORD_W-1:0] v;
    logic                        complete;
    logic                        fire;

    always_comb begin
        if (decode_mode) begin
            v = {group_bits_reg, f_item.idx};
            complete = f_item.last || (group_count_reg == 2'd3);
        end else begin
            v = {group_bits_reg[15:0], f_item.data};
            complete = f_item.last || (group_count_reg == 2'd2);
        end
    end

    // left-align a short final group
    always_comb begin
        grp.last = f_item.last;
        grp.word = v;
        if (decode_mode) begin
            case (group_count_reg)
                2'd0:    grp.word = v << 18;
                2'd1:    grp.word = v << 12;
                2'd2:    grp.word = v << 6;
                default: grp.word = v;
            endcase
        end else begin
            case (group_count_reg)
                2'd0:    grp.word = v << 16;
                2'd1:    grp.word = v << 8;
                default: grp.word = v;
            endcase
        end
    end

    assign grp_valid = f_valid && complete;
    assign f_ready   = !complete || grp_ready;
    assign fire      = f_valid && f_ready;

    always_comb begin
        group_bits_next  = group_bits_reg;
        group_count_next = group_count_reg;
        if (clear) begin
            group_bits_next  = '0;
            group_count_next = 2'd0;
        end else if (fire) begin
            if (complete) begin
                group_bits_next  = '0;
                group_count_next = 2'd0;
            end else begin
                group_bits_next  = v[kb64_pkg::BITS_W-1:0];
                group_count_next = group_count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_bits_reg  <= '0;
            group_count_reg <= 2'd0;
        end else begin
            group_bits_reg  <= group_bits_next;
            group_count_reg <= group_count_next;
        end
    end

endmodule

// ===== rtl/kb64_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kb64_emitter
// Serializes a group into results; encode reads the symbol ROM into the
// output register.
// ----------------------------------------------------------------------------
`include "keyed_base64_codec_top_assert.svh"

module kb64_emitter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       decode_mode,
    input  logic [kb64_pkg::SEL_W-1:0] enc_row,
    input  logic                       grp_valid,
    input  kb64_pkg::group_t           grp,
    output logic                       grp_ready,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,
    output logic                       m_tlast
);

    logic [kb64_pkg::WORD_W-1:0] word_reg, word_next;
    logic [1:0]                  k_reg, k_next;
    logic                        emit_valid_reg, emit_valid_next;
    logic                        last_reg;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [7:0]                  m_tdata_reg;
    logic                        m_tlast_reg;
    logic                        adv;
    logic                        final_k;
    logic                        load;

    assign final_k   = decode_mode ? (k_reg == 2'd2) : (k_reg == 2'd3);
    assign adv       = emit_valid_reg && (!m_tvalid_reg || m_tready);
    assign grp_ready = !emit_valid_reg || (adv && final_k);
    assign load      = grp_valid && grp_ready;

    always_comb begin
        word_next       = word_reg;
        k_next          = k_reg;
        emit_valid_next = emit_valid_reg;
        if (adv) begin
            word_next       = decode_mode ? (word_reg << 8) : (word_reg << 6);
            k_next          = k_reg + 2'd1;
            emit_valid_next = !final_k;
        end
        if (load) begin
            word_next       = grp.word;
            k_next          = 2'd0;
            emit_valid_next = 1'b1;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (adv) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_valid_reg <= 1'b0;
            k_reg          <= 2'd0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            emit_valid_reg <= emit_valid_next;
            k_reg          <= k_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        if (load) begin
            last_reg <= grp.last;
        end
        if (adv) begin
            m_tdata_reg <= decode_mode ? word_reg[23:16]
                                       : kb64_pkg::symbol_of(enc_row, word_reg[23:18]);
            m_tlast_reg <= last_reg && final_k;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `KB64_ASSERT_SAME(a_dec_three, emit_valid_reg && decode_mode, k_reg != 2'd3, "decode emitted a fourth byte")
    `KB64_ASSERT_NEXT(a_load_start, load, emit_valid_reg && (k_reg == 2'd0), "group load did not restart emitter")
    `KB64_ASSERT_SAME(a_rise_src, $rose(m_tvalid_reg), $past(emit_valid_reg), "result without a pending group")
    `KB64_ASSERT_SAME(a_busy_block, emit_valid_reg && !adv, !grp_ready, "group taken while emitter busy")

endmodule

// ===== rtl/keyed_base64_codec_top.sv =====
`timescale 1ns / 1ps
// A closed group is loaded into the emitter's word register, each result then into the
// output register. Encode gives four symbols per three bytes and gathers the next group
// meanwhile; decode takes 1 item per cycle unless the output stalls, 3 bytes per 4 sextets.
// Reset (aresetn low, synchronous) empties the pipeline, clears the open group and
// sets alphabet 0 and encode mode.
// ----------------------------------------------------------------------------
// keyed_base64_codec_top
// Streaming base64-style codec with ten selectable permuted alphabets.
// ----------------------------------------------------------------------------
module keyed_base64_codec_top #(
    parameter int NUM_ALPHABETS = kb64_pkg::NUM_ALPHABETS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] in_byte
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_char
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kb64_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kb64_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [kb64_pkg::SEL_W-1:0] sel_reg;
    logic                       decode_mode_reg;
    logic                       cfg_write;
    logic                       mode_clear;
    logic                       sel_ok;
    logic [kb64_pkg::SEL_W-1:0] enc_row;

    logic                  f_valid;
    logic                  f_ready;
    kb64_pkg::front_item_t f_item;
    logic                  grp_valid;
    logic                  grp_ready;
    kb64_pkg::group_t      grp;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign mode_clear = cfg_write && (cfg_index == kb64_pkg::REG_DECODE_MODE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg         <= '0;
            decode_mode_reg <= 1'b0;
        end else if (cfg_write) begin
            if (cfg_index == kb64_pkg::REG_ALPHABET_SELECT) begin
                sel_reg <= cfg_data[kb64_pkg::SEL_W-1:0];
            end else if (cfg_index == kb64_pkg::REG_DECODE_MODE) begin
                decode_mode_reg <= cfg_data[0];
            end
        end
    end

    assign sel_ok = ({1'b0, sel_reg} < 5'(NUM_ALPHABETS)) &&
                    ({1'b0, sel_reg} < 5'(kb64_pkg::TABLE_ROWS));
    assign enc_row = sel_ok ? sel_reg : '0;

    kb64_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .sel_ok   (sel_ok),
        .sel      (sel_reg),
        .f_valid  (f_valid),
        .f_item   (f_item),
        .f_ready  (f_ready)
    );

    kb64_packer u_packer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .decode_mode (decode_mode_reg),
        .clear       (mode_clear),
        .f_valid     (f_valid),
        .f_item      (f_item),
        .f_ready     (f_ready),
        .grp_valid   (grp_valid),
        .grp         (grp),
        .grp_ready   (grp_ready)
    );

    kb64_emitter u_emitter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .decode_mode (decode_mode_reg),
        .enc_row     (enc_row),
        .grp_valid   (grp_valid),
        .grp         (grp),
        .grp_ready   (grp_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
